[sv/fmsc_pkg.sv]
package fmsc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // speed = t*100/45 = t*20/9, done as (t * SPD_RECIP) >> SPD_SHIFT for 1 <= t <= 44
    localparam int SPD_SHIFT   = 12;
    localparam int SPD_RECIP   = 9103;
    localparam int SPD_PROD_W  = 20;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;

    typedef enum logic [1:0] {
        MODE_MANUAL   = 2'd0,
        MODE_SCHEDULE = 2'd1,
        MODE_AUTO     = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_SWITCH    = 3'd1,
        KIND_SET_SPEED = 3'd2,
        KIND_AUTO      = 3'd3,
        KIND_ADD       = 3'd4,
        KIND_DELETE    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        OUT_DONE     = 3'd0,
        OUT_IGNORED  = 3'd1,
        OUT_INVALID  = 3'd2,
        OUT_FULL     = 3'd3,
        OUT_BAD_SLOT = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic       on;
        logic [6:0] speed;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_mode              mode;
        logic signed [7:0]  thresh;
    } t_cfg;

    function automatic logic [6:0] auto_speed(logic signed [7:0] t);
        logic [SPD_PROD_W-1:0] prod;
        prod = SPD_PROD_W'(t[5:0]) * SPD_PROD_W'(SPD_RECIP);
        if (t <= 8'sd0) begin
            auto_speed = 7'd0;
        end else if (t >= 8'sd45) begin
            auto_speed = 7'd100;
        end else begin
            auto_speed = prod[SPD_SHIFT+6:SPD_SHIFT];
        end
    endfunction

endpackage

[sv/fan_mode_schedule_controller.sv]
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------------
// request   | in        | start, busy                | i_kind i_hour i_minute i_on_flag i_level
//           |           |                            | i_temperature i_slot
// result    | out       | o_valid (one-cycle strobe) | o_fan_on o_fan_speed o_matched o_outcome
//           |           |                            | o_entries_used
// config    | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index i_cfg_data
//
// A request is taken when start is high and busy low; busy holds until the strobe is out.
// Switch, set speed, auto update, add and rejected requests go from idle straight to the done
// state; a tick scans the N entries used, a delete shifts the N-1-slot entries above the slot:
// each entry passes through the single registered table read port in a read state, then a compare/write state.
// Reset (i_rst_n low, synchronous) clears fan state, entry count, mode and threshold (30),
// not the table. No receiver stall: the result holds for the strobe cycle only; cfg ready is 1.
module fan_mode_schedule_controller import fmsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_kind,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_minute,
    input  logic              i_on_flag,
    input  logic [6:0]        i_level,
    input  logic signed [7:0] i_temperature,
    input  logic [3:0]        i_slot,
    // result
    output logic              o_valid,
    output logic              o_fan_on,
    output logic [6:0]        o_fan_speed,
    output logic              o_matched,
    output logic [2:0]        o_outcome,
    output logic [4:0]        o_entries_used,
    // config
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data
);

    t_mode             r_mode;
    logic signed [7:0] r_thresh;
    t_cfg              cfg;
    t_mem_req          mem_req;
    t_entry            rd_entry;
    logic              cfg_wr;

    // the user must make config writes land only while idle (unchecked here); they are always accepted
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MANUAL;
            r_thresh <= 8'sd30;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_MODE: begin
                    // mode code 3 is reserved: keep the current mode
                    if (i_cfg_data[1:0] != 2'd3) begin
                        r_mode <= t_mode'(i_cfg_data[1:0]);
                    end
                end
                CFG_THRESH: begin
                    r_thresh <= $signed(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.mode   = r_mode;
    assign cfg.thresh = r_thresh;

    fmsc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_on_flag      (i_on_flag),
        .i_level        (i_level),
        .i_temperature  (i_temperature),
        .i_slot         (i_slot),
        .i_cfg          (cfg),
        .o_mem          (mem_req),
        .i_rd_entry     (rd_entry),
        .o_valid        (o_valid),
        .o_fan_on       (o_fan_on),
        .o_fan_speed    (o_fan_speed),
        .o_matched      (o_matched),
        .o_outcome      (o_outcome),
        .o_entries_used (o_entries_used)
    );

    fmsc_table u_table (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

endmodule

[sv/fmsc_table.sv]
module fmsc_table import fmsc_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_entry
);

    t_entry mem [TABLE_DEPTH];
    t_entry r_rd_entry;

    // no reset: only entries below the fill count are ever read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_entry <= mem[i_req.rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

[sv/fmsc_core.sv]
module fmsc_core import fmsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_kind,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_minute,
    input  logic              i_on_flag,
    input  logic [6:0]        i_level,
    input  logic signed [7:0] i_temperature,
    input  logic [3:0]        i_slot,
    input  t_cfg              i_cfg,
    output t_mem_req          o_mem,
    input  t_entry            i_rd_entry,
    output logic              o_valid,
    output logic              o_fan_on,
    output logic [6:0]        o_fan_speed,
    output logic              o_matched,
    output logic [2:0]        o_outcome,
    output logic [4:0]        o_entries_used
);

    t_state           r_state,   n_state;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic [CNT_W-1:0] r_count,   n_count;
    logic             r_fan_on,  n_fan_on;
    logic [6:0]       r_speed,   n_speed;
    logic [4:0]       r_hour,    n_hour;
    logic [5:0]       r_minute,  n_minute;
    logic             r_matched, n_matched;
    t_outcome         r_outcome, n_outcome;

    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] slot_ext;
    logic             hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fan_on <= 1'b0;
            r_speed  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fan_on <= n_fan_on;
            r_speed  <= n_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_hour    <= n_hour;
        r_minute  <= n_minute;
        r_matched <= n_matched;
        r_outcome <= n_outcome;
    end

    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign slot_ext = CNT_W'(i_slot);
    assign hit      = (i_rd_entry.hour == r_hour) && (i_rd_entry.minute == r_minute);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_fan_on  = r_fan_on;
        n_speed   = r_speed;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_matched = r_matched;
        n_outcome = r_outcome;

        o_mem.we      = 1'b0;
        o_mem.wr_addr = r_count[IDX_W-1:0];
        o_mem.wr_data = '{hour: i_hour, minute: i_minute, on: i_on_flag, speed: i_level};
        o_mem.rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_matched = 1'b0;
                    n_outcome = OUT_DONE;
                    n_state   = S_DONE;
                    case (t_kind'(i_kind))
                        KIND_TICK: begin
                            if (i_cfg.mode != MODE_SCHEDULE) begin
                                n_outcome = OUT_IGNORED;
                            end else begin
                                n_hour   = i_hour;
                                n_minute = i_minute;
                                n_idx    = '0;
                                if (r_count != '0) begin
                                    n_state = S_SCAN_RD;
                                end
                            end
                        end
                        KIND_SWITCH: begin
                            n_fan_on = i_on_flag;
                        end
                        KIND_SET_SPEED: begin
                            n_speed = (i_level > 7'd100) ? 7'd100 : i_level;
                        end
                        KIND_AUTO: begin
                            if (i_cfg.mode != MODE_AUTO) begin
                                n_outcome = OUT_IGNORED;
                            end else begin
                                n_fan_on = i_temperature > i_cfg.thresh;
                                n_speed  = auto_speed(i_temperature);
                            end
                        end
                        KIND_ADD: begin
                            if (i_hour > 5'd23 || i_minute > 6'd59 || i_level > 7'd100) begin
                                n_outcome = OUT_INVALID;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_outcome = OUT_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        KIND_DELETE: begin
                            if (slot_ext >= r_count) begin
                                n_outcome = OUT_BAD_SLOT;
                            end else if (slot_ext + CNT_W'(1) < r_count) begin
                                // first entry to move down sits just above the slot
                                n_idx   = IDX_W'(slot_ext + CNT_W'(1));
                                n_state = S_SHIFT_RD;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            n_outcome = OUT_IGNORED;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    n_matched = 1'b1;
                    n_fan_on  = i_rd_entry.on;
                    if (i_rd_entry.on) begin
                        n_speed = i_rd_entry.speed;
                    end
                end
                if (idx_next == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = IDX_W'(idx_next);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem.we      = 1'b1;
                o_mem.wr_addr = r_idx - IDX_W'(1);
                o_mem.wr_data = i_rd_entry;
                if (idx_next < r_count) begin
                    n_idx   = IDX_W'(idx_next);
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_fan_on       = r_fan_on;
    assign o_fan_speed    = r_speed;
    assign o_matched      = r_matched;
    assign o_outcome      = r_outcome;
    assign o_entries_used = 5'(r_count);

`ifndef NO_ASSERTIONS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("result strobe not followed by idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))
                 || (r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CMP || r_state == S_SHIFT_WR) |-> (CNT_W'(r_idx) < r_count))
        else $error("table index beyond fill count");
`endif

endmodule
